>>> hdl/rmu_pkg.sv
// Shared types and constants of the rescaling metronome unit.
`default_nettype none
package rmu_pkg;

	localparam int PV_W       = 25;
	localparam int PERIOD_W   = 24;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	typedef enum logic [1:0] {
		FUNC_TICK       = 2'd0,
		FUNC_START      = 2'd1,
		FUNC_STOP       = 2'd2,
		FUNC_SET_PERIOD = 2'd3
	} rmu_func_t;

	typedef struct packed {
		rmu_func_t             func;
		logic [PERIOD_W-1:0]   period;
	} rmu_cmd_t;

	typedef struct packed {
		logic beat;
		logic running;
	} rmu_res_t;

endpackage
`default_nettype wire

>>> hdl/rmu_fifo.sv
// Two-entry register queue used between front and back and on the result side.
`default_nettype none
module rmu_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0]                   mem_q [rmu_pkg::FIFO_DEPTH];
	logic [rmu_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [rmu_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [rmu_pkg::FIFO_CNT_W-1:0]     cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (cnt_q == rmu_pkg::FIFO_CNT_W'(rmu_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/rmu_front.sv
// Front end: accepts input beats, clamps the period and queues commands.
`default_nettype none
module rmu_front #(
	parameter int TIME_WIDTH = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [1:0]                     func,
	input  wire logic signed [rmu_pkg::PV_W-1:0] period_value,
	output logic                                cmd_valid,
	output rmu_pkg::rmu_cmd_t                   cmd,
	input  wire logic                           cmd_take
);

	localparam int PW = rmu_pkg::PERIOD_W;
	localparam logic [PW-1:0] TMAX_P = (PW'(1) << TIME_WIDTH) - PW'(1);

	logic [PW-1:0]      pv_pos;
	logic [PW-1:0]      pv_min1;
	logic [PW-1:0]      pv_sat;
	rmu_pkg::rmu_cmd_t  cmd_in;
	logic               cmd_empty;

	// non-positive values become 1, values above the time range saturate
	assign pv_pos  = period_value[PW-1:0];
	assign pv_min1 = (period_value[rmu_pkg::PV_W-1] || (pv_pos == '0)) ? PW'(1) : pv_pos;
	assign pv_sat  = ((pv_min1 >> TIME_WIDTH) != '0) ? TMAX_P : pv_min1;

	assign cmd_in.func   = rmu_pkg::rmu_func_t'(func);
	assign cmd_in.period = pv_sat;

	rmu_fifo #(
		.WIDTH($bits(rmu_pkg::rmu_cmd_t))
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cmd_in),
		.full    (full),
		.pop     (cmd_take),
		.empty   (cmd_empty),
		.rd_data (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule
`default_nettype wire

>>> hdl/rmu_muldiv.sv
// Serial unit computing floor(a * b / d), saturated to the time range.
`default_nettype none
module rmu_muldiv #(
	parameter int TIME_WIDTH = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [TIME_WIDTH-1:0] a,
	input  wire logic [TIME_WIDTH-1:0] b,
	input  wire logic [TIME_WIDTH-1:0] d,
	output logic                       done,
	output logic [TIME_WIDTH-1:0]      q
);

	localparam int TW    = TIME_WIDTH;
	localparam int CNT_W = $clog2(TW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_DIV
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TW-1:0]     a_q;
	logic [TW-1:0]     d_q;
	logic [2*TW-1:0]   prod_q;
	logic              done_q;

	logic [TW:0]       mul_sum;
	logic [TW:0]       div_sh;
	logic              div_ge;
	logic [TW:0]       div_rem;
	logic              last_step;

	assign mul_sum   = {1'b0, prod_q[2*TW-1:TW]} + (prod_q[0] ? {1'b0, a_q} : '0);
	assign div_sh    = {prod_q[2*TW-1:TW], prod_q[TW-1]};
	assign div_ge    = (div_sh >= {1'b0, d_q});
	assign div_rem   = div_ge ? (div_sh - {1'b0, d_q}) : div_sh;
	assign last_step = (cnt_q == CNT_W'(TW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			a_q     <= '0;
			d_q     <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q     <= a;
						d_q     <= d;
						prod_q  <= {{TW{1'b0}}, b};
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= {mul_sum, prod_q[TW-1:1]};
					cnt_q  <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					cnt_q <= '0;
					// quotient would not fit: saturate
					if (prod_q[2*TW-1:TW] >= d_q) begin
						prod_q[TW-1:0] <= '1;
						done_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					prod_q <= {div_rem[TW-1:0], prod_q[TW-2:0], div_ge};
					cnt_q  <= cnt_q + 1'b1;
					if (last_step) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign q    = prod_q[TW-1:0];

endmodule
`default_nettype wire

>>> hdl/rmu_back.sv
// Back end: metronome state, command execution and result queue.
`default_nettype none
module rmu_back #(
	parameter int TIME_WIDTH = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire rmu_pkg::rmu_cmd_t cmd,
	output logic             cmd_take,
	input  wire logic        pop,
	output logic             empty,
	output logic             beat,
	output logic             running
);

	localparam int TW = TIME_WIDTH;
	localparam logic [TW-1:0] TMAX = '1;

	logic             active_q;
	logic [TW-1:0]    period_q;
	logic [TW-1:0]    elapsed_q;
	logic [TW-1:0]    target_q;
	logic [TW-1:0]    new_period_q;
	logic             busy_q;

	logic [TW-1:0]    gw;
	logic [TW-1:0]    e_inc;
	logic             tick_hit;
	logic [TW-1:0]    rem;
	logic             is_set;
	logic             div_start;
	logic             div_done;
	logic [TW-1:0]    div_q;
	logic [TW:0]      t_sum;
	logic             res_push;
	logic             res_full;
	rmu_pkg::rmu_res_t res_in;
	rmu_pkg::rmu_res_t res_out;

	assign gw       = TW'(cmd.period);
	assign e_inc    = (elapsed_q == TMAX) ? elapsed_q : elapsed_q + 1'b1;
	assign tick_hit = (e_inc >= target_q);
	assign rem      = (target_q > elapsed_q) ? (target_q - elapsed_q) : '0;
	assign is_set   = (cmd.func == rmu_pkg::FUNC_SET_PERIOD);
	assign t_sum    = {1'b0, elapsed_q} + {1'b0, div_q};

	assign cmd_take  = cmd_valid && !busy_q && !res_full;
	assign div_start = cmd_take && is_set && active_q;
	assign res_push  = (cmd_take && !div_start) || div_done;

	always_comb begin
		res_in.beat    = 1'b0;
		res_in.running = active_q;
		if (cmd_take) begin
			case (cmd.func)
				rmu_pkg::FUNC_TICK: res_in.beat = active_q && tick_hit;
				rmu_pkg::FUNC_START: begin
					res_in.beat    = 1'b1;
					res_in.running = 1'b1;
				end
				rmu_pkg::FUNC_STOP: res_in.running = 1'b0;
				default: res_in.beat = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			period_q     <= TW'(1);
			elapsed_q    <= '0;
			target_q     <= '0;
			new_period_q <= TW'(1);
			busy_q       <= 1'b0;
		end else begin
			if (div_done) begin
				target_q <= t_sum[TW] ? TMAX : t_sum[TW-1:0];
				period_q <= new_period_q;
				busy_q   <= 1'b0;
			end else if (cmd_take) begin
				case (cmd.func)
					rmu_pkg::FUNC_TICK: begin
						if (active_q) begin
							if (tick_hit) begin
								elapsed_q <= '0;
								target_q  <= period_q;
							end else begin
								elapsed_q <= e_inc;
							end
						end
					end
					rmu_pkg::FUNC_START: begin
						active_q  <= 1'b1;
						elapsed_q <= '0;
						target_q  <= period_q;
					end
					rmu_pkg::FUNC_STOP: active_q <= 1'b0;
					rmu_pkg::FUNC_SET_PERIOD: begin
						if (active_q) begin
							new_period_q <= gw;
							busy_q       <= 1'b1;
						end else begin
							period_q <= gw;
						end
					end
					default: active_q <= active_q;
				endcase
			end
		end
	end

	rmu_muldiv #(
		.TIME_WIDTH(TW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (gw),
		.b      (rem),
		.d      (period_q),
		.done   (div_done),
		.q      (div_q)
	);

	rmu_fifo #(
		.WIDTH($bits(rmu_pkg::rmu_res_t))
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (res_out)
	);

	assign beat    = res_out.beat;
	assign running = res_out.running;

	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result beat pushed into full queue");
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> busy_q) else $error("divider finished with no rescale pending");
	a_busy_running: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> active_q) else $error("rescale pending while stopped");
	a_busy_holds_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd_take) else $error("command taken during rescale");

endmodule
`default_nettype wire

>>> hdl/rescaling_metronome_unit.sv
// Top level of the rescaling metronome unit.
// Beat generator driven by tick commands (func 0 tick, 1 start, 2 stop, 3 set period).
// Each input beat yields exactly one result beat (beat, running), in order. Tick, start
// and stop commands, and a period change while stopped, complete at one per clock while
// no rescale is pending and the result queue has room; results are registered in the
// result queue. A period change while running rescales the remaining interval through
// a serial multiply/divide unit and holds the command queue while it runs (TIME_WIDTH
// multiply steps, one range check, TIME_WIDTH divide steps; the divide steps are skipped
// when the quotient saturates). Two-entry queues sit at the command and result sides so
// input and output stall independently.
`default_nettype none
module rescaling_metronome_unit #(
	parameter int TIME_WIDTH = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [1:0]                      func,
	input  wire logic signed [rmu_pkg::PV_W-1:0] period_value,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 beat,
	output logic                                 running
);

	logic              cmd_valid;
	logic              cmd_take;
	rmu_pkg::rmu_cmd_t cmd;

	rmu_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.period_value (period_value),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	rmu_back #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.empty     (empty),
		.beat      (beat),
		.running   (running)
	);

endmodule
`default_nettype wire
